// ----- sv/lhni_pkg.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index package
// Shared types, register codes and constants of the node index block.
// ----------------------------------------------------------------------------
package lhni_pkg;

  localparam int MAX_ORDER = 15;
  localparam int MAX_CELLS = 1024;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [1:0] REG_POLY_ORDER = 2'd0;
  localparam logic [1:0] REG_CELLS_X    = 2'd1;
  localparam logic [1:0] REG_CELLS_Y    = 2'd2;
  localparam logic [1:0] REG_CELLS_Z    = 2'd3;

  typedef struct packed {
    logic [3:0]  p;
    logic [3:0]  m;
    logic [4:0]  p1;
    logic [10:0] nx;
    logic [10:0] ny;
    logic [10:0] nz;
  } cfg_eff_t;

  typedef struct packed {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [9:0] cz;
    logic [3:0] lx;
    logic [3:0] ly;
    logic [3:0] lz;
    logic       bad;
    logic [3:0] c0;
    logic [3:0] a;
    logic [4:0] b;
    logic [4:0] c;
  } entry_t;

  typedef struct packed {
    logic [11:0] node_slot;
    logic [41:0] grid_point;
    logic [29:0] cell_number;
    logic [41:0] table_address;
    logic        bad_position;
  } result_t;

  function automatic logic [10:0] eff_cells(input logic [10:0] c);
    logic [10:0] r;
    r = (c > 11'(MAX_CELLS)) ? 11'(MAX_CELLS) : c;
    return r;
  endfunction

endpackage

// ----- sv/lhni_fifo.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index queue
// Small first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module lhni_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- sv/lhni_front.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index front end
// Range check and corner, edge, face or interior classification of a node.
// ----------------------------------------------------------------------------
module lhni_front (
  input  lhni_pkg::cfg_eff_t cfg,
  input  logic [9:0]         cell_x,
  input  logic [9:0]         cell_y,
  input  logic [9:0]         cell_z,
  input  logic [3:0]         local_x,
  input  logic [3:0]         local_y,
  input  logic [3:0]         local_z,
  output lhni_pkg::entry_t   entry
);
  import lhni_pkg::*;

  logic       bx;
  logic       by;
  logic       bz;
  logic [1:0] nb;

  assign bx = (local_x == 4'd0) || (local_x == cfg.p);
  assign by = (local_y == 4'd0) || (local_y == cfg.p);
  assign bz = (local_z == 4'd0) || (local_z == cfg.p);
  assign nb = 2'(bx) + 2'(by) + 2'(bz);

  // The slot is later formed as c0 + a + m * b + m * m * c.
  always_comb begin
    entry.cx  = cell_x;
    entry.cy  = cell_y;
    entry.cz  = cell_z;
    entry.lx  = local_x;
    entry.ly  = local_y;
    entry.lz  = local_z;
    entry.bad = ({1'b0, cell_x} >= cfg.nx) || ({1'b0, cell_y} >= cfg.ny) ||
                ({1'b0, cell_z} >= cfg.nz) || (local_x > cfg.p) ||
                (local_y > cfg.p) || (local_z > cfg.p);
    entry.c0  = 4'd8;
    entry.a   = 4'd0;
    entry.b   = 5'd0;
    entry.c   = 5'd0;
    case (nb)
      2'd3: begin
        entry.c0 = (local_z != 4'd0) ? 4'd4 : 4'd0;
        if (local_x != 4'd0) begin
          entry.c0 = entry.c0 + ((local_y != 4'd0) ? 4'd2 : 4'd1);
        end else begin
          entry.c0 = entry.c0 + ((local_y != 4'd0) ? 4'd3 : 4'd0);
        end
      end
      2'd2: begin
        if (!bx) begin
          entry.a = local_x - 4'd1;
          entry.b = ((local_y != 4'd0) ? 5'd2 : 5'd0) + ((local_z != 4'd0) ? 5'd4 : 5'd0);
        end else if (!by) begin
          entry.a = local_y - 4'd1;
          entry.b = ((local_x != 4'd0) ? 5'd1 : 5'd3) + ((local_z != 4'd0) ? 5'd4 : 5'd0);
        end else begin
          entry.a = local_z - 4'd1;
          if (local_x != 4'd0) begin
            entry.b = (local_y != 4'd0) ? 5'd11 : 5'd9;
          end else begin
            entry.b = (local_y != 4'd0) ? 5'd10 : 5'd8;
          end
        end
      end
      2'd1: begin
        if (bx) begin
          entry.a = local_y - 4'd1;
          entry.b = 5'd11 + 5'(local_z);
          entry.c = (local_x != 4'd0) ? 5'd1 : 5'd0;
        end else if (by) begin
          entry.a = local_x - 4'd1;
          entry.b = 5'd11 + 5'(local_z);
          entry.c = (local_y != 4'd0) ? 5'd3 : 5'd2;
        end else begin
          entry.a = local_x - 4'd1;
          entry.b = 5'd11 + 5'(local_y);
          entry.c = (local_z != 4'd0) ? 5'd5 : 5'd4;
        end
      end
      default: begin
        entry.a = local_x - 4'd1;
        entry.b = 5'd11 + 5'(local_y);
        entry.c = 5'd5 + 5'(local_z);
      end
    endcase
  end

endmodule

// ----- sv/lhni_back.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index back end
// Four-stage arithmetic pipeline and result queue with credit-based issue.
// ----------------------------------------------------------------------------
module lhni_back (
  input  logic               clk,
  input  logic               rst,
  input  lhni_pkg::cfg_eff_t cfg,
  input  lhni_pkg::entry_t   head,
  input  logic               head_valid,
  output logic               head_pop,
  output lhni_pkg::result_t  result,
  output logic               empty,
  input  logic               pop
);
  import lhni_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OCC_W = CNT_W + 1;

  logic [CNT_W-1:0] out_count;
  logic [2:0]       inflight;
  logic             out_full;
  logic             v1, v2, v3, v4;

  logic [13:0] s1_gx, s1_gy, s1_gz, s1_npx, s1_npy;
  logic [19:0] s1_czny;
  logic [9:0]  s1_cx, s1_cy;
  logic [7:0]  s1_mm;
  logic [8:0]  s1_mb;
  logic [8:0]  s1_p1sq;
  logic [3:0]  s1_c0, s1_a;
  logic [4:0]  s1_c;
  logic        s1_bad;

  logic [27:0] s2_t1;
  logic [19:0] s2_cyz;
  logic [12:0] s2_npe;
  logic [11:0] s2_mmc, s2_sum0;
  logic [13:0] s2_gx, s2_npx;
  logic [9:0]  s2_cx;
  logic        s2_bad;

  logic [41:0] s3_gp;
  logic [29:0] s3_cell;
  logic [11:0] s3_slot;
  logic [12:0] s3_npe;
  logic        s3_bad;

  result_t     s4;

  assign inflight = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);
  assign head_pop = head_valid && !out_full &&
                    ((OCC_W'(out_count) + OCC_W'(inflight)) < OCC_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= head_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1_gx   <= 14'(head.cx) * 14'(cfg.p) + 14'(head.lx);
    s1_gy   <= 14'(head.cy) * 14'(cfg.p) + 14'(head.ly);
    s1_gz   <= 14'(head.cz) * 14'(cfg.p) + 14'(head.lz);
    s1_npx  <= 14'(cfg.nx) * 14'(cfg.p) + 14'd1;
    s1_npy  <= 14'(cfg.ny) * 14'(cfg.p) + 14'd1;
    s1_czny <= 20'(head.cz) * 20'(cfg.ny);
    s1_cx   <= head.cx;
    s1_cy   <= head.cy;
    s1_mm   <= 8'(cfg.m) * 8'(cfg.m);
    s1_mb   <= 9'(cfg.m) * 9'(head.b);
    s1_p1sq <= 9'(cfg.p1) * 9'(cfg.p1);
    s1_c0   <= head.c0;
    s1_a    <= head.a;
    s1_c    <= head.c;
    s1_bad  <= head.bad;

    s2_t1   <= 28'(s1_gz) * 28'(s1_npy) + 28'(s1_gy);
    s2_cyz  <= s1_czny + 20'(s1_cy);
    s2_npe  <= 13'(s1_p1sq) * 13'(cfg.p1);
    s2_mmc  <= 12'(s1_mm) * 12'(s1_c);
    s2_sum0 <= 12'(s1_c0) + 12'(s1_a) + 12'(s1_mb);
    s2_gx   <= s1_gx;
    s2_npx  <= s1_npx;
    s2_cx   <= s1_cx;
    s2_bad  <= s1_bad;

    s3_gp   <= 42'(s2_t1) * 42'(s2_npx) + 42'(s2_gx);
    s3_cell <= 30'(s2_cyz) * 30'(cfg.nx) + 30'(s2_cx);
    s3_slot <= s2_sum0 + s2_mmc;
    s3_npe  <= s2_npe;
    s3_bad  <= s2_bad;

    if (s3_bad) begin
      s4 <= '{node_slot: '0, grid_point: '0, cell_number: '0, table_address: '0,
              bad_position: 1'b1};
    end else begin
      s4 <= '{node_slot: s3_slot, grid_point: s3_gp, cell_number: s3_cell,
              table_address: 42'(s3_cell) * 42'(s3_npe) + 42'(s3_slot),
              bad_position: 1'b0};
    end
  end

  lhni_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (v4),
    .wdata (s4),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

endmodule

// ----- sv/lagrange_hex_node_index.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index
// Maps a cell and local node position of a structured box mesh to the node's
// slot in the Lagrange hexahedron ordering, its global grid point number, the
// flat cell number and the connectivity table address.
//
// Input side: a transaction is taken at a clock edge with push high and full
// low. The front end checks ranges and classifies the node, then writes it to
// a four-entry queue. While the result queue has room, the back end issues one
// transaction per cycle from that queue into a four-stage multiply pipeline,
// which feeds an eight-entry result queue. Result side: the oldest result is
// shown while empty is low and leaves on an edge with pop high. Throughput is
// one transaction per cycle, set by the pipeline. When pop stays low, issue
// stops once the result queue and the pipeline together hold eight
// transactions; the input queue then fills and full rises. Reset empties both
// queues and loads poly_order 1 and 2 cells on each axis. Configuration is
// written through cfg_write, cfg_index and cfg_data; the user must do so only
// while no transaction is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module lagrange_hex_node_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [9:0]  cell_x,
  input  logic [9:0]  cell_y,
  input  logic [9:0]  cell_z,
  input  logic [3:0]  local_x,
  input  logic [3:0]  local_y,
  input  logic [3:0]  local_z,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] node_slot,
  output logic [41:0] grid_point,
  output logic [29:0] cell_number,
  output logic [41:0] table_address,
  output logic        bad_position,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import lhni_pkg::*;

  logic [3:0]  poly_order;
  logic [10:0] cells_x;
  logic [10:0] cells_y;
  logic [10:0] cells_z;
  cfg_eff_t    cfg;
  entry_t      in_entry;
  entry_t      head;
  logic        mid_empty;
  logic        head_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_order <= 4'd1;
      cells_x    <= 11'd2;
      cells_y    <= 11'd2;
      cells_z    <= 11'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POLY_ORDER: poly_order <= cfg_data[3:0];
        REG_CELLS_X:    cells_x    <= cfg_data;
        REG_CELLS_Y:    cells_y    <= cfg_data;
        REG_CELLS_Z:    cells_z    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.p  = (poly_order == 4'd0) ? 4'd1 : poly_order;
    cfg.m  = cfg.p - 4'd1;
    cfg.p1 = 5'(cfg.p) + 5'd1;
    cfg.nx = eff_cells(cells_x);
    cfg.ny = eff_cells(cells_y);
    cfg.nz = eff_cells(cells_z);
  end

  lhni_front u_front (
    .cfg     (cfg),
    .cell_x  (cell_x),
    .cell_y  (cell_y),
    .cell_z  (cell_z),
    .local_x (local_x),
    .local_y (local_y),
    .local_z (local_z),
    .entry   (in_entry)
  );

  lhni_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_entry),
    .full  (full),
    .pop   (head_pop),
    .rdata (head),
    .empty (mid_empty),
    .count (mid_count)
  );

  lhni_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!mid_empty && (mid_count != '0)),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  assign node_slot     = result.node_slot;
  assign grid_point    = result.grid_point;
  assign cell_number   = result.cell_number;
  assign table_address = result.table_address;
  assign bad_position  = result.bad_position;

endmodule

// ----- tb/lhni_checker.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index checker
// Watches the configuration port and both queue sides of the node index block.
// Every accepted input transaction gets a predicted result, and every result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lhni_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [9:0]  cell_x,
  input  logic [9:0]  cell_y,
  input  logic [9:0]  cell_z,
  input  logic [3:0]  local_x,
  input  logic [3:0]  local_y,
  input  logic [3:0]  local_z,
  input  logic        empty,
  input  logic        pop,
  input  logic [11:0] node_slot,
  input  logic [41:0] grid_point,
  input  logic [29:0] cell_number,
  input  logic [41:0] table_address,
  input  logic        bad_position,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lhni_pkg::*;

  logic [3:0]  order_q;
  logic [10:0] ncells_x_q;
  logic [10:0] ncells_y_q;
  logic [10:0] ncells_z_q;
  result_t     pending_results[$];
  int          errors = 0;

  // Slot of local node (i, j, k) in a hexahedron of order n: corners first,
  // then edge, face and interior nodes.
  function automatic int hex_slot(input int i, input int j, input int k, input int n);
    bit on_x, on_y, on_z;
    int nb, m, edges_at, faces_at, inner_at;
    on_x = (i == 0) || (i == n);
    on_y = (j == 0) || (j == n);
    on_z = (k == 0) || (k == n);
    nb = int'(on_x) + int'(on_y) + int'(on_z);
    m = n - 1;
    edges_at = 8;
    faces_at = 8 + 12 * m;
    inner_at = faces_at + 6 * m * m;
    case (nb)
      3: return ((i != 0) ? ((j != 0) ? 2 : 1) : ((j != 0) ? 3 : 0)) + ((k != 0) ? 4 : 0);
      2: begin
        if (!on_x)
          return edges_at + (i - 1) + ((j != 0) ? 2 * m : 0) + ((k != 0) ? 4 * m : 0);
        if (!on_y)
          return edges_at + (j - 1) + ((i != 0) ? m : 3 * m) + ((k != 0) ? 4 * m : 0);
        return edges_at + 8 * m + (k - 1)
               + m * ((i != 0) ? ((j != 0) ? 3 : 1) : ((j != 0) ? 2 : 0));
      end
      1: begin
        if (on_x)
          return faces_at + (j - 1) + m * (k - 1) + ((i != 0) ? m * m : 0);
        if (on_y)
          return faces_at + 2 * m * m + (i - 1) + m * (k - 1) + ((j != 0) ? m * m : 0);
        return faces_at + 4 * m * m + (i - 1) + m * (j - 1) + ((k != 0) ? m * m : 0);
      end
      default: return inner_at + (i - 1) + m * ((j - 1) + m * (k - 1));
    endcase
  endfunction

  function automatic result_t predict_node(input logic [9:0] cx, input logic [9:0] cy,
                                           input logic [9:0] cz, input logic [3:0] lx,
                                           input logic [3:0] ly, input logic [3:0] lz);
    result_t r;
    longint unsigned p, nx, ny, nz, npx, npy, gx, gy, gz, gp, flat_cell, slot, taddr;
    r = '0;
    p = (order_q == 4'd0) ? 1 : order_q;
    nx = (ncells_x_q > MAX_CELLS) ? MAX_CELLS : ncells_x_q;
    ny = (ncells_y_q > MAX_CELLS) ? MAX_CELLS : ncells_y_q;
    nz = (ncells_z_q > MAX_CELLS) ? MAX_CELLS : ncells_z_q;
    if (cx >= nx || cy >= ny || cz >= nz || lx > p || ly > p || lz > p) begin
      r.bad_position = 1'b1;
      return r;
    end
    slot = hex_slot(int'(lx), int'(ly), int'(lz), int'(p));
    npx = nx * p + 1;
    npy = ny * p + 1;
    gx = cx * p + lx;
    gy = cy * p + ly;
    gz = cz * p + lz;
    gp = (gz * npy + gy) * npx + gx;
    flat_cell = (cz * ny + cy) * nx + cx;
    taddr = flat_cell * (p + 1) * (p + 1) * (p + 1) + slot;
    r.node_slot = slot[11:0];
    r.grid_point = gp[41:0];
    r.cell_number = flat_cell[29:0];
    r.table_address = taddr[41:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      order_q = 4'd1;
      ncells_x_q = 11'd2;
      ncells_y_q = 11'd2;
      ncells_z_q = 11'd2;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_POLY_ORDER: order_q = cfg_data[3:0];
          REG_CELLS_X:    ncells_x_q = cfg_data;
          REG_CELLS_Y:    ncells_y_q = cfg_data;
          REG_CELLS_Z:    ncells_z_q = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        pending_results.push_back(predict_node(cell_x, cell_y, cell_z,
                                               local_x, local_y, local_z));
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("node_slot", 64'(want.node_slot), 64'(node_slot));
          check_field("grid_point", 64'(want.grid_point), 64'(grid_point));
          check_field("cell_number", 64'(want.cell_number), 64'(cell_number));
          check_field("table_address", 64'(want.table_address), 64'(table_address));
          check_field("bad_position", 64'(want.bad_position), 64'(bad_position));
        end
      end
    end
    fail_count <= errors;
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Lagrange hexahedron node index testbench
// Drives node transactions into the block under a series of mesh settings,
// first a directed set of corner, edge, face, interior and out-of-range
// nodes, then mostly valid random nodes with some noise. Both queue sides
// idle in random bursts, and once the result side holds off long enough for
// the block to fill up. The checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lhni_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 170;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [9:0] cz;
    logic [3:0] lx;
    logic [3:0] ly;
    logic [3:0] lz;
  } node_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [9:0]  cell_x = '0;
  logic [9:0]  cell_y = '0;
  logic [9:0]  cell_z = '0;
  logic [3:0]  local_x = '0;
  logic [3:0]  local_y = '0;
  logic [3:0]  local_z = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [11:0] node_slot;
  logic [41:0] grid_point;
  logic [29:0] cell_number;
  logic [41:0] table_address;
  logic        bad_position;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_POLY_ORDER;
  logic [10:0] cfg_data = '0;
  int          fail_count;
  int          outstanding;

  int          idle_level = 0;
  logic        hold_go = 1'b0;
  logic        held = 1'b0;
  int          hold_left = 0;
  int          pop_gap = 0;
  int          cycles = 0;

  int unsigned cur_order = 1;
  int unsigned lim_x = 2;
  int unsigned lim_y = 2;
  int unsigned lim_z = 2;

  lagrange_hex_node_index dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .local_x(local_x), .local_y(local_y), .local_z(local_z),
    .empty(empty), .pop(pop),
    .node_slot(node_slot), .grid_point(grid_point), .cell_number(cell_number),
    .table_address(table_address), .bad_position(bad_position),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lhni_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .local_x(local_x), .local_y(local_y), .local_z(local_z),
    .empty(empty), .pop(pop),
    .node_slot(node_slot), .grid_point(grid_point), .cell_number(cell_number),
    .table_address(table_address), .bad_position(bad_position),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      held <= 1'b0;
      hold_left <= 0;
      pop_gap <= 0;
    end else if (hold_go && !held) begin
      held <= 1'b1;
      hold_left <= 100;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (pop_gap != 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if (idle_level > 0 && $urandom_range(0, 15) < idle_level) begin
      pop_gap <= $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic offer_node(input logic [9:0] cx, input logic [9:0] cy, input logic [9:0] cz,
                            input logic [3:0] lx, input logic [3:0] ly, input logic [3:0] lz);
    if (idle_level > 0 && $urandom_range(0, 15) < idle_level) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    cell_x <= cx;
    cell_y <= cy;
    cell_z <= cz;
    local_x <= lx;
    local_y <= ly;
    local_z <= lz;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned order, input int unsigned nx,
                            input int unsigned ny, input int unsigned nz);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_POLY_ORDER;
    cfg_data <= 11'(order);
    @(posedge clk);
    cfg_index <= REG_CELLS_X;
    cfg_data <= 11'(nx);
    @(posedge clk);
    cfg_index <= REG_CELLS_Y;
    cfg_data <= 11'(ny);
    @(posedge clk);
    cfg_index <= REG_CELLS_Z;
    cfg_data <= 11'(nz);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_order = (order == 0) ? 1 : order;
    lim_x = (nx > MAX_CELLS) ? MAX_CELLS : nx;
    lim_y = (ny > MAX_CELLS) ? MAX_CELLS : ny;
    lim_z = (nz > MAX_CELLS) ? MAX_CELLS : nz;
  endtask

  function automatic logic [3:0] local_pos(input int unsigned p);
    if ($urandom_range(0, 1) == 0)
      return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'(p);
    return 4'($urandom_range(0, p));
  endfunction

  function automatic int unsigned random_cells();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 2047);
    return $urandom_range(1, 40);
  endfunction

  function automatic node_t random_node();
    node_t n;
    n.cx = 10'($urandom);
    n.cy = 10'($urandom);
    n.cz = 10'($urandom);
    n.lx = 4'($urandom);
    n.ly = 4'($urandom);
    n.lz = 4'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      if (lim_x != 0) n.cx = 10'($urandom_range(0, lim_x - 1));
      if (lim_y != 0) n.cy = 10'($urandom_range(0, lim_y - 1));
      if (lim_z != 0) n.cz = 10'($urandom_range(0, lim_z - 1));
      n.lx = local_pos(cur_order);
      n.ly = local_pos(cur_order);
      n.lz = local_pos(cur_order);
      if (cur_order < MAX_ORDER && $urandom_range(0, 15) == 0)
        n.ly = 4'($urandom_range(cur_order + 1, MAX_ORDER));
    end
    return n;
  endfunction

  initial begin
    node_t n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_level <= 1;

    // Order one, two cells per axis: all corners and range violations.
    offer_node(0, 0, 0, 0, 0, 0);
    offer_node(1, 0, 0, 1, 0, 0);
    offer_node(0, 1, 0, 1, 1, 0);
    offer_node(1, 1, 0, 0, 1, 0);
    offer_node(0, 0, 1, 0, 0, 1);
    offer_node(1, 0, 1, 1, 0, 1);
    offer_node(1, 1, 1, 1, 1, 1);
    offer_node(0, 1, 1, 0, 1, 1);
    offer_node(2, 0, 0, 0, 0, 0);
    offer_node(0, 0, 0, 0, 2, 0);
    offer_node(1023, 1023, 1023, 15, 15, 15);

    // Highest order on the largest mesh: one node of every kind.
    set_config(15, 1024, 1024, 1024);
    offer_node(1023, 1023, 1023, 15, 15, 15);
    offer_node(1023, 1023, 1023, 7, 7, 7);
    offer_node(0, 0, 0, 3, 0, 0);
    offer_node(5, 6, 7, 15, 3, 15);
    offer_node(9, 8, 7, 0, 0, 5);
    offer_node(0, 0, 0, 0, 3, 4);
    offer_node(2, 3, 4, 3, 0, 4);
    offer_node(1, 2, 3, 3, 4, 15);

    // Order zero with an oversized x count, first with a zero and then with a one y count.
    set_config(0, 2047, 0, 1);
    offer_node(0, 0, 0, 1, 1, 1);
    offer_node(1023, 0, 0, 0, 0, 0);
    set_config(0, 2047, 1, 1);
    offer_node(1023, 0, 0, 1, 1, 0);
    offer_node(0, 0, 0, 2, 0, 0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_config(1, 1, 1, 1);
        1: set_config(15, 1024, 1024, 1024);
        2: set_config(0, 2047, 2047, 2047);
        3: set_config(2, 3, 0, 5);
        default: set_config($urandom_range(0, 15), random_cells(), random_cells(),
                            random_cells());
      endcase
      idle_level <= (phase == NUM_PHASES - 1) ? 0 : $urandom_range(0, 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 4 && k == 10) hold_go <= 1'b1;
        n = random_node();
        offer_node(n.cx, n.cy, n.cz, n.lx, n.ly, n.lz);
      end
    end

    drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lhni_pkg.sv
sv/lhni_fifo.sv
sv/lhni_front.sv
sv/lhni_back.sv
sv/lagrange_hex_node_index.sv
tb/lhni_checker.sv
tb/tb_top.sv
